// ===== design/ahc_pkg.sv =====
// Package for the automatic headlight controller.
// Holds the mode codes, register indexes and field widths shared by the design.
// No dependencies.
`default_nettype none

package ahc_pkg;

   localparam int unsigned POT_BITS   = 12;
   localparam int unsigned LIMIT_BITS = 13;
   localparam int unsigned SUM_BITS   = 16;
   localparam int unsigned TICK_BITS  = 8;
   localparam int unsigned CSR_BITS   = 3;

   localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

   typedef enum logic [1:0] {
      MODE_FORCED_OFF = 2'd0,
      MODE_ON         = 2'd1,
      MODE_SENSED     = 2'd2,
      MODE_STOPPED    = 2'd3
   } mode_type;

   typedef enum logic [CSR_BITS-1:0] {
      REG_OFF_LIMIT    = 3'd0,
      REG_AUTO_LIMIT   = 3'd1,
      REG_DARK_LIMIT   = 3'd2,
      REG_BRIGHT_LIMIT = 3'd3,
      REG_ON_DELAY     = 3'd4,
      REG_OFF_DELAY    = 3'd5
   } csr_index_type;

endpackage

`default_nettype wire

// ===== design/auto_headlight_controller.sv =====
// Top level of the automatic headlight controller.
// Depends on ahc_pkg and ahc_cell (the moving window is a chain of ahc_cell stages).
//
//   channel | direction | word
//   req_    | in        | one 50 ms tick: light sample, mode pot, engine flag
//   rsp_    | out       | lamp drive, active mode, window sum
//   csr_    | in        | register write: index and data, always ready
//
// On each accepted tick the window shifts if the engine runs, and the sum and the
// lamp decision are formed from the chain tail and registered in the output stage.
// A tick can be accepted every cycle while the skid register is empty; the result
// and skid registers let req_ keep flowing while one result waits on rsp_.
// Synchronous reset clears the window, the running sum, the lamp and the dwell count
// and loads the register defaults.
`default_nettype none

module auto_headlight_controller #(
   parameter int unsigned WINDOW      = 10,
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: light_sample[11:0], mode_pot[23:12], engine_running[24], zero pad
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [31:0] req_tdata,
   // rsp_tdata: lamp_on[0], active_mode[2:1], light_sum[18:3], zero pad
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [23:0] rsp_tdata,
   input  wire logic        csr_valid,
   output      logic        csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_data
);

   localparam int unsigned SUM_BITS  = ahc_pkg::SUM_BITS;
   localparam int unsigned TICK_BITS = ahc_pkg::TICK_BITS;
   localparam int unsigned LIM_BITS  = ahc_pkg::LIMIT_BITS;

   // Input fields.
   logic [11:0]                 light_sample;
   logic [ahc_pkg::POT_BITS-1:0] mode_pot;
   logic                        engine_running;
   logic                        req_accept;

   assign light_sample   = req_tdata[11:0];
   assign mode_pot       = req_tdata[23:12];
   assign engine_running = req_tdata[24];
   assign req_accept     = req_tvalid && req_tready;

   // Configuration registers.
   logic [LIM_BITS-1:0]  off_limit_ff, auto_limit_ff;
   logic [SUM_BITS-1:0]  dark_limit_ff, bright_limit_ff;
   logic [TICK_BITS-1:0] on_delay_ff, off_delay_ff;
   logic                 csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_limit_ff    <= 13'd1352;
         auto_limit_ff   <= 13'd2703;
         dark_limit_ff   <= 16'd26618;
         bright_limit_ff <= 16'd24570;
         on_delay_ff     <= 8'd20;
         off_delay_ff    <= 8'd40;
      end else if (csr_write) begin
         unique case (csr_index)
            ahc_pkg::REG_OFF_LIMIT:    off_limit_ff    <= csr_data[LIM_BITS-1:0];
            ahc_pkg::REG_AUTO_LIMIT:   auto_limit_ff   <= csr_data[LIM_BITS-1:0];
            ahc_pkg::REG_DARK_LIMIT:   dark_limit_ff   <= csr_data[SUM_BITS-1:0];
            ahc_pkg::REG_BRIGHT_LIMIT: bright_limit_ff <= csr_data[SUM_BITS-1:0];
            ahc_pkg::REG_ON_DELAY:     on_delay_ff     <= csr_data[TICK_BITS-1:0];
            ahc_pkg::REG_OFF_DELAY:    off_delay_ff    <= csr_data[TICK_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Sample window: a chain of cells, the oldest sample falls out of the tail.
   logic                   shift_en;
   logic [SAMPLE_BITS-1:0] tap [WINDOW+1];

   assign shift_en = req_accept && engine_running;
   assign tap[0]   = light_sample[SAMPLE_BITS-1:0];

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      ahc_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (shift_en),
         .sample_in  (tap[i]),
         .sample_out (tap[i+1])
      );
   end

   // Tick decision.
   logic [SUM_BITS-1:0]  sum_ff, sum_in;
   logic                 lamp_ff, lamp_in;
   logic [TICK_BITS-1:0] dwell_ff, dwell_in;
   logic [SUM_BITS-1:0]  sum_new;
   logic [TICK_BITS-1:0] dwell_inc;
   ahc_pkg::mode_type    mode;

   always_comb begin
      sum_new   = sum_ff - SUM_BITS'(tap[WINDOW]) + SUM_BITS'(tap[0]);
      dwell_inc = (dwell_ff == ahc_pkg::TICK_MAX) ? dwell_ff : dwell_ff + 1'b1;
      sum_in    = sum_ff;
      lamp_in   = lamp_ff;
      dwell_in  = dwell_ff;
      if (!engine_running) begin
         mode     = ahc_pkg::MODE_STOPPED;
         lamp_in  = 1'b0;
         dwell_in = '0;
      end else begin
         if (LIM_BITS'(mode_pot) < off_limit_ff) begin
            mode = ahc_pkg::MODE_FORCED_OFF;
         end else if (LIM_BITS'(mode_pot) < auto_limit_ff) begin
            mode = ahc_pkg::MODE_SENSED;
         end else begin
            mode = ahc_pkg::MODE_ON;
         end
         sum_in = sum_new;
         if (mode == ahc_pkg::MODE_ON) begin
            lamp_in  = 1'b1;
            dwell_in = '0;
         end else if (mode == ahc_pkg::MODE_FORCED_OFF) begin
            lamp_in  = 1'b0;
            dwell_in = '0;
         end else if (!lamp_ff && sum_new < dark_limit_ff) begin
            if (dwell_inc >= on_delay_ff) begin
               lamp_in  = 1'b1;
               dwell_in = '0;
            end else begin
               dwell_in = dwell_inc;
            end
         end else if (lamp_ff && sum_new > bright_limit_ff) begin
            if (dwell_inc >= off_delay_ff) begin
               lamp_in  = 1'b0;
               dwell_in = '0;
            end else begin
               dwell_in = dwell_inc;
            end
         end else begin
            dwell_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         lamp_ff  <= 1'b0;
         dwell_ff <= '0;
      end else if (req_accept) begin
         sum_ff   <= sum_in;
         lamp_ff  <= lamp_in;
         dwell_ff <= dwell_in;
      end
   end

   // Output stage: result register plus a skid register.
   logic [23:0] word_new;
   logic [23:0] out_word_ff, skid_word_ff;
   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   logic        rsp_accept;

   assign word_new   = {5'd0, sum_in, mode, lamp_in};
   assign rsp_accept = rsp_tvalid && rsp_tready;
   assign req_tready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (rsp_accept) begin
         out_valid_in  = skid_valid_ff || req_accept;
         skid_valid_in = 1'b0;
      end else if (req_accept) begin
         out_valid_in  = 1'b1;
         skid_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // The skid word is only loaded when the result register is held full.
   always_ff @(posedge clock) begin
      if (rsp_accept && skid_valid_ff) begin
         out_word_ff <= skid_word_ff;
      end else if (req_accept && (rsp_accept || !out_valid_ff)) begin
         out_word_ff <= word_new;
      end
      if (req_accept && out_valid_ff && !rsp_accept) begin
         skid_word_ff <= word_new;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_word_ff;

endmodule

`default_nettype wire

// ===== design/ahc_cell.sv =====
// One stage of the light sample window of the headlight controller.
// Holds one sample and hands it to the next stage whenever a sample is shifted in.
// No dependencies.
`default_nettype none

module ahc_cell #(
   parameter int unsigned SAMPLE_BITS = 12
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   shift_en,
   input  wire logic [SAMPLE_BITS-1:0] sample_in,
   output      logic [SAMPLE_BITS-1:0] sample_out
);

   logic [SAMPLE_BITS-1:0] sample_ff;
   logic [SAMPLE_BITS-1:0] sample_hold_in;

   always_comb begin
      sample_hold_in = shift_en ? sample_in : sample_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_hold_in;
      end
   end

   assign sample_out = sample_ff;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// Self-checking bench for auto_headlight_controller: ticks go in on req_, lamp reports
// come back on rsp_, and register settings are written through csr_ between phases.
// Depends on ahc_pkg and the controller RTL only.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned TICK_WINDOW   = 10;
   localparam int unsigned LIGHT_BITS    = 12;
   localparam int unsigned SETTLE_CYCLES = 6;

   localparam logic [ahc_pkg::CSR_BITS-1:0] REG_SPARE_LO = 3'd6;
   localparam logic [ahc_pkg::CSR_BITS-1:0] REG_SPARE_HI = 3'd7;

   typedef struct packed {
      logic                         engine_running;
      logic [ahc_pkg::POT_BITS-1:0] mode_pot;
      logic [LIGHT_BITS-1:0]        light_sample;
   } tick_type;

   typedef struct packed {
      logic [ahc_pkg::SUM_BITS-1:0] light_sum;
      ahc_pkg::mode_type            active_mode;
      logic                         lamp_on;
   } lamp_report_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   // Register copies as the block should hold them.
   logic [ahc_pkg::LIMIT_BITS-1:0] cfg_off_limit;
   logic [ahc_pkg::LIMIT_BITS-1:0] cfg_auto_limit;
   logic [ahc_pkg::SUM_BITS-1:0]   cfg_dark_limit;
   logic [ahc_pkg::SUM_BITS-1:0]   cfg_bright_limit;
   logic [ahc_pkg::TICK_BITS-1:0]  cfg_on_delay;
   logic [ahc_pkg::TICK_BITS-1:0]  cfg_off_delay;

   // Predicted controller state.
   logic [LIGHT_BITS-1:0]         window_mem [TICK_WINDOW];
   int unsigned                   window_slot;
   logic [ahc_pkg::SUM_BITS-1:0]  window_total;
   logic                          lamp_lit;
   logic [ahc_pkg::TICK_BITS-1:0] dwell;

   tick_type        tick_queue [$];
   lamp_report_type pending_reports [$];

   int  ticks_sent = 0;
   int  ticks_taken = 0;
   int  reports_checked = 0;
   int  fault_count = 0;
   int  settings_used = 0;
   int  auto_switches = 0;
   int  stopped_ticks = 0;
   int  gap_pct = 0;
   int  stall_pct = 0;
   int  req_gap = 0;
   int  rsp_stall = 0;
   bit  req_taken = 1'b0;
   bit  csr_done = 1'b0;

   auto_headlight_controller #(
      .WINDOW      (TICK_WINDOW),
      .SAMPLE_BITS (LIGHT_BITS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #4 clock = ~clock;

   // Counts a qualifying tick and says whether the hold time has now been met.
   function automatic bit dwell_done(logic [ahc_pkg::TICK_BITS-1:0] needed);
      if (dwell != ahc_pkg::TICK_MAX)
         dwell = dwell + 1'b1;
      if (dwell >= needed) begin
         dwell = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic lamp_report_type advance_headlight(tick_type t);
      lamp_report_type   r;
      ahc_pkg::mode_type m;
      if (!t.engine_running) begin
         lamp_lit = 1'b0;
         dwell = '0;
         m = ahc_pkg::MODE_STOPPED;
         stopped_ticks++;
      end else begin
         if (t.mode_pot < cfg_off_limit)
            m = ahc_pkg::MODE_FORCED_OFF;
         else if (t.mode_pot < cfg_auto_limit)
            m = ahc_pkg::MODE_SENSED;
         else
            m = ahc_pkg::MODE_ON;
         window_total = window_total - window_mem[window_slot] + t.light_sample;
         window_mem[window_slot] = t.light_sample;
         window_slot = (window_slot == TICK_WINDOW - 1) ? 0 : window_slot + 1;
         if (m == ahc_pkg::MODE_ON) begin
            lamp_lit = 1'b1;
            dwell = '0;
         end else if (m == ahc_pkg::MODE_FORCED_OFF) begin
            lamp_lit = 1'b0;
            dwell = '0;
         end else if (!lamp_lit && window_total < cfg_dark_limit) begin
            if (dwell_done(cfg_on_delay)) begin
               lamp_lit = 1'b1;
               auto_switches++;
            end
         end else if (lamp_lit && window_total > cfg_bright_limit) begin
            if (dwell_done(cfg_off_delay)) begin
               lamp_lit = 1'b0;
               auto_switches++;
            end
         end else begin
            dwell = '0;
         end
      end
      r.lamp_on = lamp_lit;
      r.active_mode = m;
      r.light_sum = window_total;
      return r;
   endfunction

   // Request driver: holds a word until it is taken, with random gaps between words.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // word still waiting for req_tready
      end else if (req_gap > 0) begin
         req_tvalid <= 1'b0;
         req_gap--;
      end else if (tick_queue.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         req_gap = $urandom_range(0, 6);
      end else begin
         req_tdata <= {7'd0, tick_queue.pop_front()};
         req_tvalid <= 1'b1;
      end
      req_taken = 1'b0;
   end

   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         rsp_stall = $urandom_range(0, 6);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts on every accepted tick and checks every accepted report.
   always @(posedge clock) begin
      lamp_report_type want;
      lamp_report_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pending_reports.push_back(advance_headlight(tick_type'(req_tdata[24:0])));
            ticks_taken++;
            req_taken = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = lamp_report_type'(rsp_tdata[18:0]);
            if (pending_reports.size() == 0) begin
               $display("%0t: report expected none, got %h", $time, rsp_tdata);
               fault_count++;
            end else begin
               want = pending_reports.pop_front();
               reports_checked++;
               if (got.lamp_on !== want.lamp_on) begin
                  $display("%0t: lamp_on expected %0d, got %0d",
                           $time, want.lamp_on, got.lamp_on);
                  fault_count++;
               end
               if (got.active_mode !== want.active_mode) begin
                  $display("%0t: active_mode expected %0d, got %0d",
                           $time, want.active_mode, got.active_mode);
                  fault_count++;
               end
               if (got.light_sum !== want.light_sum) begin
                  $display("%0t: light_sum expected %0d, got %0d",
                           $time, want.light_sum, got.light_sum);
                  fault_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               ahc_pkg::REG_OFF_LIMIT:
                  cfg_off_limit = csr_data[ahc_pkg::LIMIT_BITS-1:0];
               ahc_pkg::REG_AUTO_LIMIT:
                  cfg_auto_limit = csr_data[ahc_pkg::LIMIT_BITS-1:0];
               ahc_pkg::REG_DARK_LIMIT:
                  cfg_dark_limit = csr_data[ahc_pkg::SUM_BITS-1:0];
               ahc_pkg::REG_BRIGHT_LIMIT:
                  cfg_bright_limit = csr_data[ahc_pkg::SUM_BITS-1:0];
               ahc_pkg::REG_ON_DELAY:
                  cfg_on_delay = csr_data[ahc_pkg::TICK_BITS-1:0];
               ahc_pkg::REG_OFF_DELAY:
                  cfg_off_delay = csr_data[ahc_pkg::TICK_BITS-1:0];
               default: ;
            endcase
            csr_done = 1'b1;
         end
      end
   end

   task automatic add_tick(logic [LIGHT_BITS-1:0] light,
                           logic [ahc_pkg::POT_BITS-1:0] pot, bit running);
      tick_type t;
      t.light_sample = light;
      t.mode_pot = pot;
      t.engine_running = running;
      tick_queue.push_back(t);
      ticks_sent++;
   endtask

   // Picks a pot reading for the wanted mode, often right on a threshold.
   function automatic logic [ahc_pkg::POT_BITS-1:0] pot_for(ahc_pkg::mode_type m);
      int lo;
      int hi;
      lo = 0;
      hi = 4095;
      if (m == ahc_pkg::MODE_FORCED_OFF) begin
         hi = int'(cfg_off_limit) - 1;
      end else if (m == ahc_pkg::MODE_SENSED) begin
         lo = cfg_off_limit;
         hi = int'(cfg_auto_limit) - 1;
      end else begin
         lo = (cfg_off_limit > cfg_auto_limit) ? cfg_off_limit : cfg_auto_limit;
      end
      if (hi > 4095)
         hi = 4095;
      if (lo > hi) begin
         lo = 0;
         hi = 4095;
      end
      if ($urandom_range(0, 7) == 0)
         return ($urandom_range(0, 1) == 1) ? lo[ahc_pkg::POT_BITS-1:0]
                                            : hi[ahc_pkg::POT_BITS-1:0];
      return ahc_pkg::POT_BITS'($urandom_range(lo, hi));
   endfunction

   // Queues runs of ticks that hold one mode and one light level, so the dwell counter
   // gets a chance to run out, broken up by engine stops and stray samples.
   task automatic fill_runs(int count, int stop_pct, int longest);
      int                made;
      int                len;
      int                kind;
      int                base;
      int                light;
      ahc_pkg::mode_type m;
      made = 0;
      while (made < count) begin
         kind = $urandom_range(0, 99);
         if (kind < stop_pct) begin
            m = ahc_pkg::MODE_STOPPED;
            len = $urandom_range(1, 4);
         end else if (kind < stop_pct + 12) begin
            m = ahc_pkg::MODE_ON;
            len = $urandom_range(1, 6);
         end else if (kind < stop_pct + 24) begin
            m = ahc_pkg::MODE_FORCED_OFF;
            len = $urandom_range(1, 6);
         end else begin
            m = ahc_pkg::MODE_SENSED;
            len = $urandom_range(1, longest);
         end
         case ($urandom_range(0, 4))
            0, 1:    base = $urandom_range(0, 2400);
            2, 3:    base = $urandom_range(2700, 4095);
            default: base = $urandom_range(0, 4095);
         endcase
         for (int i = 0; i < len && made < count; i++) begin
            light = base + int'($urandom_range(0, 600)) - 300;
            if (light < 0)
               light = 0;
            if (light > 4095)
               light = 4095;
            if ($urandom_range(0, 15) == 0)
               light = $urandom_range(0, 4095);
            add_tick(light[LIGHT_BITS-1:0],
                     (m == ahc_pkg::MODE_STOPPED) ?
                        ahc_pkg::POT_BITS'($urandom_range(0, 4095)) : pot_for(m),
                     m != ahc_pkg::MODE_STOPPED);
            made++;
         end
      end
   endtask

   // Waits until every queued tick has been taken and every report has come back.
   task automatic settle();
      do
         @(negedge clock);
      while (ticks_taken != ticks_sent || pending_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [ahc_pkg::CSR_BITS-1:0] idx, logic [31:0] value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do
         @(negedge clock);
      while (!csr_done);
      csr_done = 1'b0;
   endtask

   task automatic apply_settings(int off_lim, int auto_lim, int dark_lim, int bright_lim,
                                 int on_ticks, int off_ticks, bit spare);
      write_reg(ahc_pkg::REG_OFF_LIMIT, off_lim);
      write_reg(ahc_pkg::REG_AUTO_LIMIT, auto_lim);
      write_reg(ahc_pkg::REG_DARK_LIMIT, dark_lim);
      write_reg(ahc_pkg::REG_BRIGHT_LIMIT, bright_lim);
      write_reg(ahc_pkg::REG_ON_DELAY, on_ticks);
      write_reg(ahc_pkg::REG_OFF_DELAY, off_ticks);
      if (spare) begin
         // Writes to unused indexes must leave every setting alone.
         write_reg(REG_SPARE_LO, $urandom());
         write_reg(REG_SPARE_HI, $urandom());
      end
      csr_valid <= 1'b0;
      settings_used++;
      @(negedge clock);
   endtask

   initial begin
      int off_lim;
      int auto_lim;
      int dark_lim;
      int bright_lim;
      cfg_off_limit = 13'd1352;
      cfg_auto_limit = 13'd2703;
      cfg_dark_limit = 16'd26618;
      cfg_bright_limit = 16'd24570;
      cfg_on_delay = 8'd20;
      cfg_off_delay = 8'd40;
      foreach (window_mem[i])
         window_mem[i] = '0;
      window_slot = 0;
      window_total = '0;
      lamp_lit = 1'b0;
      dwell = '0;
      gap_pct = 20;
      stall_pct = 20;
      settings_used = 1;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed ticks under the reset settings: stopped engine, each mode and the
      // pot readings either side of both thresholds, then a dark stretch cut by a stop.
      add_tick(12'hFFF, 12'hFFF, 1'b0);
      add_tick(12'hFFF, 12'h000, 1'b1);
      add_tick(12'h000, 12'hFFF, 1'b1);
      add_tick(12'hAAA, ahc_pkg::POT_BITS'(cfg_off_limit - 1'b1), 1'b1);
      add_tick(12'h555, ahc_pkg::POT_BITS'(cfg_off_limit), 1'b1);
      add_tick(12'hFFF, ahc_pkg::POT_BITS'(cfg_auto_limit - 1'b1), 1'b1);
      add_tick(12'h000, ahc_pkg::POT_BITS'(cfg_auto_limit), 1'b1);
      add_tick(12'h123, 12'h800, 1'b0);
      repeat (14) add_tick(12'h000, 12'h800, 1'b1);
      add_tick(12'h000, 12'h800, 1'b0);
      add_tick(12'hFFF, 12'h800, 1'b1);
      settle();

      apply_settings(1352, 2703, 26618, 24570, 3, 5, 1'b1);
      fill_runs(300, 4, 30);
      settle();

      // Always automatic, always dark and always bright: the lamp toggles constantly.
      gap_pct = 10;
      stall_pct = 30;
      apply_settings(0, 4096, 65535, 0, 0, 1, 1'b0);
      fill_runs(200, 6, 12);
      settle();

      // Automatic but never dark nor bright, then forced OFF, then forced ON.
      apply_settings(0, 4096, 0, 65535, 1, 1, 1'b0);
      fill_runs(40, 5, 20);
      settle();
      apply_settings(4096, 4096, 0, 65535, 1, 1, 1'b0);
      fill_runs(40, 5, 20);
      settle();
      apply_settings(0, 0, 0, 65535, 1, 1, 1'b0);
      fill_runs(40, 5, 20);
      settle();

      // Longest hold times with no engine stop, so the dwell counter reaches its top.
      gap_pct = 15;
      stall_pct = 15;
      apply_settings(0, 4096, 65535, 0, 255, 255, 1'b0);
      fill_runs(560, 0, 300);
      settle();

      repeat (3) begin
         gap_pct = $urandom_range(0, 30);
         stall_pct = $urandom_range(0, 30);
         off_lim = $urandom_range(0, 3000);
         auto_lim = $urandom_range(off_lim, 4096);
         dark_lim = $urandom_range(8000, 36000);
         bright_lim = dark_lim - int'($urandom_range(0, 4000));
         apply_settings(off_lim, auto_lim, dark_lim, bright_lim,
                        $urandom_range(1, 12), $urandom_range(1, 12), 1'b1);
         fill_runs(120, 5, 40);
         settle();
      end

      // Closing stretch at full rate with the reset settings back in place.
      gap_pct = 0;
      stall_pct = 0;
      apply_settings(1352, 2703, 26618, 24570, 20, 40, 1'b0);
      fill_runs(250, 3, 80);
      settle();

      $display("Checked %0d ticks and %0d reports over %0d register settings.",
               ticks_taken, reports_checked, settings_used);
      $display("Automatic mode switched the lamp %0d times; %0d ticks had the engine off.",
               auto_switches, stopped_ticks);
      if (fault_count == 0)
         $display("auto_headlight_controller verification clean");
      else
         $display("auto_headlight_controller verification failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d ticks taken of %0d.", ticks_taken, ticks_sent);
      $display("auto_headlight_controller verification failed");
      $finish;
   end

endmodule

// ===== files.f =====
design/ahc_pkg.sv
design/ahc_cell.sv
design/auto_headlight_controller.sv
bench/testbench.sv
